FILE: rtl/bml_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pkg: shared definitions for the bilinear map lookup
// Field widths, arithmetic widths and the command and status groups that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package bml_pkg;

  localparam int DIM_DEF = 16;

  localparam int CRD_W = 16;   // coordinate and axis point width
  localparam int OFF_W = 9;    // flat entry offset width
  localparam int VAL_W = 16;   // written value width
  localparam int RES_W = 8;    // map cell and result width
  localparam int DIF_W = 17;   // signed coordinate difference
  localparam int PRD_W = 34;   // product of two differences
  localparam int TRM_W = 43;   // product times a cell value
  localparam int NUM_W = 46;   // sum of four weighted corners
  localparam int CNT_W = 4;    // step counter of the multi-cycle states

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic load;
    logic wr;
    logic rd_hi;
    logic rd_lo;
    logic clip;
    logic prime;
    logic scan;
    logic fetch;
    logic mac;
    logic norm;
    logic div;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic scan_done;
    logic fetch_done;
    logic mac_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/bml_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_ctrl: sequencing state machine
// Steps one item through an entry write, or through axis clipping, interval
// scan, corner fetch, accumulation and division, and issues one command per state.
// ----------------------------------------------------------------------------
module bml_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire bml_pkg::sts_t sts,
  output bml_pkg::cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_WR    = 12'b0000_0000_0010,
    S_RDHI  = 12'b0000_0000_0100,
    S_RDLO  = 12'b0000_0000_1000,
    S_CLIP  = 12'b0000_0001_0000,
    S_PRIME = 12'b0000_0010_0000,
    S_SCAN  = 12'b0000_0100_0000,
    S_FETCH = 12'b0000_1000_0000,
    S_MAC   = 12'b0001_0000_0000,
    S_NORM  = 12'b0010_0000_0000,
    S_DIV   = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = sts.is_write ? S_WR : S_RDHI;
      S_WR:    state_nxt = S_FIN;
      S_RDHI:  state_nxt = S_RDLO;
      S_RDLO:  state_nxt = S_CLIP;
      S_CLIP:  state_nxt = S_PRIME;
      S_PRIME: state_nxt = S_SCAN;
      S_SCAN:  if (sts.scan_done) state_nxt = S_FETCH;
      S_FETCH: if (sts.fetch_done) state_nxt = S_MAC;
      S_MAC:   if (sts.mac_done) state_nxt = S_NORM;
      S_NORM:  state_nxt = S_DIV;
      S_DIV:   if (sts.div_done) state_nxt = S_FIN;
      S_FIN:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && in_tvalid;
    cmd.wr     = (state_r == S_WR);
    cmd.rd_hi  = (state_r == S_RDHI);
    cmd.rd_lo  = (state_r == S_RDLO);
    cmd.clip   = (state_r == S_CLIP);
    cmd.prime  = (state_r == S_PRIME);
    cmd.scan   = (state_r == S_SCAN);
    cmd.fetch  = (state_r == S_FETCH);
    cmd.mac    = (state_r == S_MAC);
    cmd.norm   = (state_r == S_NORM);
    cmd.div    = (state_r == S_DIV);
    cmd.finish = (state_r == S_FIN);
  end

endmodule
`default_nettype wire

FILE: rtl/bml_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bml_dp: table storage and arithmetic
// Holds the map and axis memories, the interval scan, a shared multiplier
// for the corner weights and a restoring divider for the final quotient.
// ----------------------------------------------------------------------------
module bml_dp #(
  parameter int DIM = bml_pkg::DIM_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bml_pkg::cmd_t               cmd,
  output bml_pkg::sts_t                    sts,
  input  wire logic                        in_func,
  input  wire logic [bml_pkg::CRD_W-1:0]   in_x,
  input  wire logic [bml_pkg::CRD_W-1:0]   in_y,
  input  wire logic [bml_pkg::OFF_W-1:0]   in_off,
  input  wire logic [bml_pkg::VAL_W-1:0]   in_val,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [bml_pkg::RES_W-1:0]        out_value,
  output logic                             out_err
);

  localparam int AW      = $clog2(DIM);
  localparam int CELLS   = DIM * DIM;
  localparam int CW      = $clog2(CELLS);
  localparam int ENTRIES = CELLS + 2 * DIM;
  localparam int EW      = ($clog2(ENTRIES + 1) > bml_pkg::OFF_W) ?
                           $clog2(ENTRIES + 1) : bml_pkg::OFF_W;
  localparam int CRD_W   = bml_pkg::CRD_W;
  localparam int RES_W   = bml_pkg::RES_W;
  localparam int NUM_W   = bml_pkg::NUM_W;
  localparam int CNT_W   = bml_pkg::CNT_W;

  function automatic logic [CRD_W-1:0] clip(input logic [CRD_W-1:0] c,
                                            input logic [CRD_W-1:0] hi,
                                            input logic [CRD_W-1:0] lo);
    logic [CRD_W-1:0] t;
    t = (c > hi) ? hi : c;
    return (t < lo) ? lo : t;
  endfunction

  // Item registers.
  logic [CRD_W-1:0]            x_r, y_r;
  logic [bml_pkg::OFF_W-1:0]   off_r;
  logic [bml_pkg::VAL_W-1:0]   val_r;

  // Memories.
  logic [RES_W-1:0] map_mem [CELLS];
  logic [CRD_W-1:0] xax_mem [DIM];
  logic [CRD_W-1:0] yax_mem [DIM];
  logic [RES_W-1:0] cell_rd_r;
  logic [CRD_W-1:0] xrd_r, yrd_r;

  // Scan state.
  logic [AW-1:0]    k_r;
  logic [CRD_W-1:0] xhi_r, yhi_r, xc_r, yc_r, xprev_r, yprev_r;
  logic [CRD_W-1:0] xa0_r, xa1_r, ya0_r, ya1_r;
  logic [AW-1:0]    xi0_r, yi0_r;
  logic             xfnd_r, yfnd_r;

  // Arithmetic state.
  logic [CNT_W-1:0]                  cnt_r;
  logic [RES_W-1:0]                  cells_r [4];
  logic signed [bml_pkg::DIF_W-1:0]  dxl_r, dxh_r, dyl_r, dyh_r;
  logic signed [bml_pkg::PRD_W-1:0]  den_r, w_r;
  logic signed [NUM_W-1:0]           acc_r, num_r;
  logic [bml_pkg::PRD_W-1:0]         dmag_r;
  logic                              dzero_r;
  logic [NUM_W-1:0]                  rem_r, dsh_r;
  logic [RES_W-1:0]                  q_r;
  logic                              err_r;

  // Output register.
  logic                              out_valid_r;
  logic [RES_W-1:0]                  out_value_r;
  logic                              out_err_r;

  // Write decode.
  logic [EW-1:0] off_e;
  logic          wr_cell, wr_x, wr_y;
  logic [AW-1:0] idx_x, idx_y;

  assign off_e   = EW'(off_r);
  assign wr_cell = off_e < EW'(CELLS);
  assign wr_x    = !wr_cell && (off_e < EW'(CELLS + DIM));
  assign wr_y    = !wr_cell && !wr_x && (off_e < EW'(ENTRIES));
  assign idx_x   = AW'(off_e - EW'(CELLS));
  assign idx_y   = AW'(off_e - EW'(CELLS + DIM));

  // Read addresses.
  logic [AW-1:0] ax_addr;
  logic [AW-1:0] xsel, ysel;
  logic [CW-1:0] cell_addr;

  always_comb begin
    ax_addr = '0;
    if (cmd.rd_hi || cmd.clip) begin
      ax_addr = AW'(DIM - 1);
    end else if (cmd.rd_lo) begin
      ax_addr = '0;
    end else if (cmd.prime) begin
      ax_addr = AW'(DIM - 2);
    end else if (cmd.scan) begin
      ax_addr = k_r - 1'b1;
    end
  end

  assign xsel      = cnt_r[0] ? (xi0_r + 1'b1) : xi0_r;
  assign ysel      = cnt_r[1] ? (yi0_r + 1'b1) : yi0_r;
  assign cell_addr = CW'(ysel) * CW'(DIM) + CW'(xsel);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_cell) begin
      map_mem[off_e[CW-1:0]] <= val_r[RES_W-1:0];
    end
    cell_rd_r <= map_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_x) begin
      xax_mem[idx_x] <= val_r;
    end
    if (cmd.wr && wr_y) begin
      yax_mem[idx_y] <= val_r;
    end
    xrd_r <= xax_mem[ax_addr];
    yrd_r <= yax_mem[ax_addr];
  end

  // Interval scan, walking down from the top point.
  logic xmatch, ymatch;

  assign xmatch = (xc_r == xprev_r) || ((xc_r < xprev_r) && (xc_r > xrd_r)) ||
                  (k_r == '0);
  assign ymatch = (yc_r == yprev_r) || ((yc_r < yprev_r) && (yc_r > yrd_r)) ||
                  (k_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_x;
      y_r   <= in_y;
      off_r <= in_off;
      val_r <= in_val;
    end
    if (cmd.rd_lo) begin
      xhi_r <= xrd_r;
      yhi_r <= yrd_r;
    end
    if (cmd.clip) begin
      xc_r <= clip(x_r, xhi_r, xrd_r);
      yc_r <= clip(y_r, yhi_r, yrd_r);
    end
    if (cmd.prime) begin
      k_r     <= AW'(DIM - 2);
      xprev_r <= xrd_r;
      yprev_r <= yrd_r;
    end else if (cmd.scan) begin
      k_r     <= k_r - 1'b1;
      xprev_r <= xrd_r;
      yprev_r <= yrd_r;
      if (!xfnd_r && xmatch) begin
        xi0_r <= k_r;
        xa0_r <= xrd_r;
        xa1_r <= xprev_r;
      end
      if (!yfnd_r && ymatch) begin
        yi0_r <= k_r;
        ya0_r <= yrd_r;
        ya1_r <= yprev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfnd_r <= 1'b0;
      yfnd_r <= 1'b0;
    end else if (cmd.prime) begin
      xfnd_r <= 1'b0;
      yfnd_r <= 1'b0;
    end else if (cmd.scan) begin
      xfnd_r <= xfnd_r || xmatch;
      yfnd_r <= yfnd_r || ymatch;
    end
  end

  // Corner fetch, weights, accumulation and division.
  logic signed [bml_pkg::DIF_W-1:0] ddx, ddy, dxs, dys;
  logic signed [bml_pkg::TRM_W-1:0] term;
  logic [1:0]                       cidx;
  logic                             neg, sat, special;

  assign ddx  = $signed({1'b0, xa1_r}) - $signed({1'b0, xa0_r});
  assign ddy  = $signed({1'b0, ya1_r}) - $signed({1'b0, ya0_r});
  assign dxs  = cnt_r[0] ? dxh_r : dxl_r;
  assign dys  = cnt_r[1] ? dyh_r : dyl_r;
  assign cidx = cnt_r[1:0] - 2'd1;
  assign term = w_r * $signed({1'b0, cells_r[cidx]});

  assign neg     = num_r[NUM_W-1];
  assign sat     = $unsigned(num_r) >= NUM_W'({dmag_r, 8'h00});
  assign special = dzero_r || neg || sat;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      if (cnt_r != '0) begin
        cells_r[cidx] <= cell_rd_r;
      end else begin
        dxl_r <= $signed({1'b0, xa1_r}) - $signed({1'b0, xc_r});
        dxh_r <= $signed({1'b0, xc_r}) - $signed({1'b0, xa0_r});
        dyl_r <= $signed({1'b0, ya1_r}) - $signed({1'b0, yc_r});
        dyh_r <= $signed({1'b0, yc_r}) - $signed({1'b0, ya0_r});
        den_r <= ddx * ddy;
      end
    end
    if (cmd.mac) begin
      if (cnt_r < CNT_W'(4)) begin
        w_r <= dxs * dys;
      end
      if (cnt_r == '0) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + NUM_W'(term);
      end
    end
    if (cmd.norm) begin
      dzero_r <= (den_r == '0);
      if (den_r < 0) begin
        num_r  <= -acc_r;
        dmag_r <= $unsigned(-den_r);
      end else begin
        num_r  <= acc_r;
        dmag_r <= $unsigned(den_r);
      end
    end
    if (cmd.wr) begin
      q_r <= '0;
    end else if (cmd.div) begin
      if (cnt_r == '0) begin
        rem_r <= $unsigned(num_r);
        dsh_r <= NUM_W'({dmag_r, 7'd0});
        if (dzero_r) begin
          q_r <= cells_r[0];
        end else if (neg) begin
          q_r <= '0;
        end else if (sat) begin
          q_r <= '1;
        end else begin
          q_r <= '0;
        end
      end else begin
        dsh_r <= dsh_r >> 1;
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r[3'(CNT_W'(8) - cnt_r)] <= 1'b1;
        end
      end
    end
    if (cmd.load) begin
      err_r <= 1'b0;
    end else if (cmd.wr) begin
      err_r <= !(wr_cell || wr_x || wr_y);
    end
  end

  // Step counter shared by the fetch, accumulate and divide states.
  logic step_on;

  assign step_on = (cmd.fetch && !sts.fetch_done) || (cmd.mac && !sts.mac_done) ||
                   (cmd.div && !sts.div_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= step_on ? cnt_r + 1'b1 : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish && sts.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && sts.out_free) begin
      out_value_r <= q_r;
      out_err_r   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;

  always_comb begin
    sts            = '0;
    sts.is_write   = in_func;
    sts.scan_done  = (k_r == '0);
    sts.fetch_done = (cnt_r == CNT_W'(4));
    sts.mac_done   = (cnt_r == CNT_W'(4));
    sts.div_done   = ((cnt_r == '0) && special) || (cnt_r == CNT_W'(8));
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

FILE: rtl/bilinear_map_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_map_lookup: DIM x DIM map with bilinear interpolation
// Stores an 8-bit map and two 16-bit axes written entry by entry, and
// answers lookups with the exactly computed, truncated bilinear value.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  in_*      slave      tdata: x_coord, y_coord, entry_offset, entry_value;
//                       tuser: func
//  out_*     master     tdata: interp_value; tuser: write_error
//
// A write passes through the write state to the finish state, where its result is
// loaded once the output is free. A lookup steps through the axis scan, which walks
// one point per cycle through the axis memories, the corner fetch, in which the four
// corners come one per cycle from the single map port, the accumulation, in which
// the weights share one multiplier, and the division, where the divider makes one quotient bit
// per cycle. One item is in work at a time. The output register holds a
// finished result while the next item is taken in; a stalled output stops
// the next item only at its final step. Reset is synchronous and active
// low; it clears control state only, the table memories stay as they are.
//
module bilinear_map_lookup #(
  parameter int DIM = bml_pkg::DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata, from bit 0: x_coord[15:0], y_coord[15:0], entry_offset[8:0],
  // entry_value[15:0], zero padding
  input  wire logic [bml_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: func (0 lookup, 1 write)
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata, from bit 0: interp_value[7:0]
  output logic [bml_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // tuser: write_error
  output logic                                   out_tuser
);

  bml_pkg::cmd_t cmd;
  bml_pkg::sts_t sts;

  bml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Unpack the input transfer into its fields.
  bml_dp #(
    .DIM (DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_x      (in_tdata[15:0]),
    .in_y      (in_tdata[31:16]),
    .in_off    (in_tdata[40:32]),
    .in_val    (in_tdata[56:41]),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_value (out_tdata),
    .out_err   (out_tuser)
  );

`ifndef SYNTHESIS
  // A write error always comes with a zero value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("write error result carries a nonzero value");

  // After a transfer the input side closes until the item is done.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready right after a transfer");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");
`endif

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bilinear_map_lookup
// Fills the map and both axes with entry writes, then mixes lookups, table
// rewrites and bad offsets, and checks every result transfer against a
// bilinear predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int DIM   = 16;
  localparam int CELLS = DIM * DIM;
  localparam int ENTRIES = CELLS + 2 * DIM;
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        func;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [8:0]  entry_offset;
    logic [15:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [7:0] interp_value;
    logic       write_error;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bml_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bml_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  always #5 clk = ~clk;

  bilinear_map_lookup #(.DIM(DIM)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Predictor copy of the table.
  logic [7:0]  cell_mem [CELLS];
  logic [15:0] x_pts [DIM];
  logic [15:0] y_pts [DIM];

  item_t   pending_items[$];
  result_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  bit hold_off = 1'b0;

  // Clips a coordinate to an axis and returns the low index of its interval.
  function automatic int interval_low(input logic [15:0] pts [DIM],
                                      input logic [15:0] c_in,
                                      output logic [15:0] c_out);
    logic [15:0] c;
    c = c_in;
    if (c > pts[DIM-1]) c = pts[DIM-1];
    if (c < pts[0]) c = pts[0];
    c_out = c;
    for (int i = DIM - 1; i > 0; i--) begin
      if (c == pts[i]) return i - 1;
      if (c < pts[i] && c > pts[i-1]) return i - 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] bilinear(input logic [15:0] xin, input logic [15:0] yin);
    logic [15:0] xc, yc;
    int xi, yi;
    longint x0, x1, y0, y1, a, b, c, d, num, den, q;
    xi = interval_low(x_pts, xin, xc);
    yi = interval_low(y_pts, yin, yc);
    x0 = x_pts[xi]; x1 = x_pts[xi+1];
    y0 = y_pts[yi]; y1 = y_pts[yi+1];
    a = cell_mem[yi*DIM + xi];
    b = cell_mem[yi*DIM + xi + 1];
    c = cell_mem[(yi+1)*DIM + xi];
    d = cell_mem[(yi+1)*DIM + xi + 1];
    den = (x1 - x0) * (y1 - y0);
    if (den == 0) return a[7:0];
    num = a*(x1-xc)*(y1-yc) + b*(xc-x0)*(y1-yc) + c*(x1-xc)*(yc-y0) + d*(xc-x0)*(yc-y0);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) return 8'd0;
    q = num / den;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  // Applies one accepted item to the predictor and queues its result.
  function automatic void predict_item(input item_t it);
    result_t r;
    r = '0;
    if (it.func == FUNC_LOOKUP) begin
      r.interp_value = bilinear(it.x_coord, it.y_coord);
    end else if (it.entry_offset >= ENTRIES) begin
      r.write_error = 1'b1;
    end else if (it.entry_offset < CELLS) begin
      cell_mem[it.entry_offset] = it.entry_value[7:0];
    end else if (it.entry_offset < CELLS + DIM) begin
      x_pts[it.entry_offset - CELLS] = it.entry_value;
    end else begin
      y_pts[it.entry_offset - CELLS - DIM] = it.entry_value;
    end
    expected_results.push_back(r);
  endfunction

  function automatic item_t mk_write(input int off, input logic [15:0] val);
    item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.entry_offset = off[8:0];
    it.entry_value = val;
    it.x_coord = 16'($urandom);
    it.y_coord = 16'($urandom);
    return it;
  endfunction

  function automatic item_t mk_lookup(input logic [15:0] x, input logic [15:0] y);
    item_t it;
    it = '0;
    it.func = FUNC_LOOKUP;
    it.x_coord = x;
    it.y_coord = y;
    it.entry_offset = 9'($urandom);
    it.entry_value = 16'($urandom);
    return it;
  endfunction

  // Queues writes for a whole axis starting at the given base with random
  // rising steps; the 16-bit points wrap if the sum passes their range.
  task automatic push_axis(input int first_off, input int base, input int max_step);
    int p;
    p = base;
    for (int i = 0; i < DIM; i++) begin
      pending_items.push_back(mk_write(first_off + i, 16'(p)));
      p += $urandom_range(max_step, 1);
    end
  endtask

  // Sender: bursts of valid with random gaps. tvalid is only changed when
  // no transfer is pending or one has just completed.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_item(item_t'({in_tuser, in_tdata[15:0], in_tdata[31:16],
                              in_tdata[40:32], in_tdata[56:41]}));
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item_t it;
          it = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.func;
          in_tdata <= {7'd0, it.entry_value, it.entry_offset, it.y_coord, it.x_coord};
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(12, 0);
            gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(60, 1);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls on a pattern of its own, and holds off entirely while
  // the long-stall window is open.
  int rx_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      rx_phase <= rx_phase + 1;
      if (hold_off) out_tready <= 1'b0;
      else if (rx_phase % 400 < 150) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(3, 0) != 0);
    end
  end

  // Monitor: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: interp_value=%0d write_error=%0d",
               out_tdata, out_tuser);
        errors++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_tdata !== e.interp_value) begin
          $error("interp_value expected %0d actual %0d", e.interp_value, out_tdata);
          errors++;
        end
        if (out_tuser !== e.write_error) begin
          $error("write_error expected %0d actual %0d", e.write_error, out_tuser);
          errors++;
        end
      end
    end
  end

  // Long receiver stall, counted in cycles in its own process.
  initial begin
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("bilinear_map_lookup regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full table first, since no lookup may read an unwritten entry.
    for (int i = 0; i < CELLS; i++) pending_items.push_back(mk_write(i, 16'($urandom)));
    pending_items.push_back(mk_write(0, 16'hFF00));   // low byte zero, upper bits ignored
    pending_items.push_back(mk_write(CELLS - 1, 16'h00FF));
    push_axis(CELLS, 0, 4000);
    push_axis(CELLS + DIM, 100, 4000);
    // Extremes of the coordinates: clipping on both ends.
    pending_items.push_back(mk_lookup(16'h0000, 16'h0000));
    pending_items.push_back(mk_lookup(16'hFFFF, 16'hFFFF));
    pending_items.push_back(mk_lookup(16'h0000, 16'hFFFF));
    pending_items.push_back(mk_lookup(16'hFFFF, 16'h0000));
    // Offsets past the end, including the first bad one and the largest.
    pending_items.push_back(mk_write(ENTRIES, 16'hFFFF));
    pending_items.push_back(mk_write(511, 16'hFFFF));
    // Degenerate interval: two equal X points, then lookup on them.
    pending_items.push_back(mk_write(CELLS + 1, 16'd0));
    pending_items.push_back(mk_lookup(16'd0, 16'd200));
    // Non-monotone X axis: point 1 above point 2.
    pending_items.push_back(mk_write(CELLS + 1, 16'hF000));
    pending_items.push_back(mk_lookup(16'hE000, 16'd5000));
    pending_items.push_back(mk_lookup(16'd10, 16'd5000));
    push_axis(CELLS, 0, 4000);

    // Random part: mostly lookups on valid axes, some rewrites and noise.
    while (pending_items.size() < 650) begin
      k = $urandom_range(99, 0);
      if (k < 65) begin
        pending_items.push_back(mk_lookup(16'($urandom_range(70000, 0)),
                                          16'($urandom_range(70000, 0))));
      end else if (k < 85) begin
        pending_items.push_back(mk_write($urandom_range(CELLS - 1, 0), 16'($urandom)));
      end else if (k < 92) begin
        pending_items.push_back(mk_write($urandom_range(511, ENTRIES), 16'($urandom)));
      end else if (k < 96) begin
        pending_items.push_back(mk_write(CELLS + DIM + $urandom_range(DIM - 1, 0),
                                         16'($urandom)));
      end else begin
        push_axis(($urandom_range(1, 0) != 0) ? CELLS : CELLS + DIM,
                  $urandom_range(3000, 0), $urandom_range(4369, 1));
      end
    end

    wait (pending_items.size() == 0 && !in_tvalid);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d result transfers over table writes, bad offsets, clipped,",
             n_results);
    $display("degenerate, non-monotone and random interpolating lookups.");
    if (errors == 0) begin
      $display("bilinear_map_lookup regression: pass");
    end else begin
      $display("bilinear_map_lookup regression: fail");
    end
    $finish;
  end

endmodule
